// ===== rtl/abls_pkg.sv =====
// Shared constants for the averaged brake and light selector.
// Holds field widths, register indexes and reset values; no dependencies.
package abls_pkg;

    localparam int unsigned SAMPLE_W   = 12;
    localparam int unsigned SWITCH_W   = 16;
    localparam int unsigned LEVEL_W    = 11;
    localparam int unsigned AVG_W      = 12;

    localparam int unsigned S_TDATA_W  = 32;
    localparam int unsigned S_TUSER_W  = 1;
    localparam int unsigned M_TDATA_W  = 32;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    localparam int unsigned WINDOW_LOG2_DEFAULT = 5;

    // Register indexes on the configuration port
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_THRESHOLD  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SWITCH_THRESHOLD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_OFF_LEVEL        = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ON_LEVEL         = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BRAKE_LEVEL      = 3'd4;

    // Reset values of the configuration registers
    localparam logic [SAMPLE_W-1:0] BRAKE_THRESHOLD_RST  = 12'd2000;
    localparam logic [SWITCH_W-1:0] SWITCH_THRESHOLD_RST = 16'd1500;
    localparam logic [LEVEL_W-1:0]  OFF_LEVEL_RST        = 11'd0;
    localparam logic [LEVEL_W-1:0]  ON_LEVEL_RST         = 11'd500;
    localparam logic [LEVEL_W-1:0]  BRAKE_LEVEL_RST      = 11'd2000;

    typedef logic [SAMPLE_W-1:0] sample_t;
    typedef logic [SWITCH_W-1:0] switch_t;
    typedef logic [LEVEL_W-1:0]  level_t;
    typedef logic [AVG_W-1:0]    avg_t;

endpackage

// ===== rtl/averaged_brake_and_light_selector.sv =====
// Top level of the averaged brake and light selector.
// Depends on abls_pkg for widths, register indexes and reset values.
// Holds the sample ring, the running sum, the output decision and the stream ports.

// Each transfer on the slave side is one service tick: an optional 12-bit
// converter sample (flagged in tuser) and the lights switch value. A flagged
// sample replaces the oldest of 2^WINDOW_LOG2 ring entries and updates a
// running sum; the average is that sum shifted right by WINDOW_LOG2. Every
// tick yields exactly one result transfer: the rear duty level (brake level
// when the average is below the brake threshold, else the on or off level from
// the switch), the lamp drive, the brake flag and the average. The block takes
// one tick per clock cycle unless m_tready stalls; the running-sum update sets
// the rate: one subtract and one add against the ring entry fetched the cycle
// before. A tick passes the middle stage, then the result register. The ring is
// a memory with a registered read port; per-entry valid bits cleared at reset
// stand in for the zeroed ring, so there is no clearing pass and ticks are taken
// right after reset. Configuration writes are meant for idle periods only.
module averaged_brake_and_light_selector #(
    parameter int unsigned WINDOW_LOG2 = abls_pkg::WINDOW_LOG2_DEFAULT
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // Slave side
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // fields from bit 0: adc_sample[11:0], switch_value[27:12], zero fill
    input  logic [abls_pkg::S_TDATA_W-1:0]   s_tdata,
    // fields from bit 0: sample_valid[0]
    input  logic [abls_pkg::S_TUSER_W-1:0]   s_tuser,
    // Master side
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // fields from bit 0: pwm_level[10:0], lights_on[11], brake_active[12],
    // average[24:13], zero fill
    output logic [abls_pkg::M_TDATA_W-1:0]   m_tdata,
    // Configuration write port
    input  logic                             cfg_we,
    input  logic [abls_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [abls_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import abls_pkg::*;

    localparam int unsigned DEPTH = 1 << WINDOW_LOG2;
    localparam int unsigned SUM_W = SAMPLE_W + WINDOW_LOG2;
    localparam int unsigned FILL_W = M_TDATA_W - (LEVEL_W + 2 + AVG_W);

    // Configuration registers
    sample_t brake_threshold_reg;
    switch_t switch_threshold_reg;
    level_t  off_level_reg;
    level_t  on_level_reg;
    level_t  brake_level_reg;

    // Ring, valid bits and running state
    sample_t                  ring_mem [DEPTH];
    logic [DEPTH-1:0]         slot_valid_reg;
    sample_t                  rd_data_reg;
    logic                     rd_valid_reg;
    logic [WINDOW_LOG2-1:0]   idx_reg;
    logic [WINDOW_LOG2-1:0]   idx_next;
    logic [SUM_W-1:0]         sum_reg;
    logic [SUM_W-1:0]         sum_next;

    // Middle stage: average after this tick and the switch value
    logic    s1_valid_reg;
    avg_t    s1_avg_reg;
    switch_t s1_switch_reg;

    // Result register
    logic    out_valid_reg;
    level_t  out_level_reg;
    logic    out_lights_reg;
    logic    out_brake_reg;
    avg_t    out_avg_reg;

    // Unpacked input fields
    logic    in_sample_valid;
    sample_t in_sample;
    switch_t in_switch;

    logic    s_accept;
    logic    s1_adv;
    sample_t old_sample;
    avg_t    avg_next;
    logic    brake_next;
    logic    lights_next;
    level_t  level_next;

    assign in_sample_valid = s_tuser[0];
    assign in_sample       = s_tdata[SAMPLE_W-1:0];
    assign in_switch       = s_tdata[SAMPLE_W +: SWITCH_W];

    // Handshakes: the result register drains, the middle stage moves into it,
    // and a new tick enters whenever the middle stage frees up.
    assign s1_adv   = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !s1_valid_reg || s1_adv;
    assign s_accept = s_tvalid && s_tready;

    // Configuration writes; indexes past the list are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brake_threshold_reg  <= BRAKE_THRESHOLD_RST;
            switch_threshold_reg <= SWITCH_THRESHOLD_RST;
            off_level_reg        <= OFF_LEVEL_RST;
            on_level_reg         <= ON_LEVEL_RST;
            brake_level_reg      <= BRAKE_LEVEL_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_BRAKE_THRESHOLD:  brake_threshold_reg  <= cfg_data[SAMPLE_W-1:0];
                REG_SWITCH_THRESHOLD: switch_threshold_reg <= cfg_data[SWITCH_W-1:0];
                REG_OFF_LEVEL:        off_level_reg        <= cfg_data[LEVEL_W-1:0];
                REG_ON_LEVEL:         on_level_reg         <= cfg_data[LEVEL_W-1:0];
                REG_BRAKE_LEVEL:      brake_level_reg      <= cfg_data[LEVEL_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sum update. The entry at idx_reg was fetched last cycle; an entry never
    // written since reset counts as zero.
    always_comb
    begin
        old_sample = rd_valid_reg ? rd_data_reg : '0;
        idx_next   = idx_reg;
        sum_next   = sum_reg;
        if (s_accept && in_sample_valid)
        begin
            idx_next = idx_reg + 1'b1;
            sum_next = sum_reg - {{WINDOW_LOG2{1'b0}}, old_sample}
                               + {{WINDOW_LOG2{1'b0}}, in_sample};
        end
        avg_next = sum_next[WINDOW_LOG2 +: AVG_W];
    end

    // Ring write at the current slot; read ahead at the slot the next tick
    // will use. The two addresses differ whenever a write takes place.
    always_ff @(posedge clk)
    begin
        if (s_accept && in_sample_valid)
        begin
            ring_mem[idx_reg] <= in_sample;
        end
        rd_data_reg <= ring_mem[idx_next];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_valid_reg <= '0;
            rd_valid_reg   <= 1'b0;
            idx_reg        <= '0;
            sum_reg        <= '0;
        end
        else
        begin
            if (s_accept && in_sample_valid)
            begin
                slot_valid_reg[idx_reg] <= 1'b1;
            end
            rd_valid_reg <= slot_valid_reg[idx_next];
            idx_reg      <= idx_next;
            sum_reg      <= sum_next;
        end
    end

    // Middle stage: hold the post-update average with its switch value
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            s1_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            s1_avg_reg    <= avg_next;
            s1_switch_reg <= in_switch;
        end
    end

    // Output decision: brake wins, then the switch picks on or off level
    always_comb
    begin
        brake_next  = (s1_avg_reg < brake_threshold_reg);
        lights_next = (s1_switch_reg > switch_threshold_reg);
        if (brake_next)
        begin
            level_next = brake_level_reg;
        end
        else if (lights_next)
        begin
            level_next = on_level_reg;
        end
        else
        begin
            level_next = off_level_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || m_tready)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_adv)
        begin
            out_level_reg  <= level_next;
            out_lights_reg <= lights_next;
            out_brake_reg  <= brake_next;
            out_avg_reg    <= s1_avg_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{FILL_W{1'b0}}, out_avg_reg, out_brake_reg, out_lights_reg,
                       out_level_reg};

    // A prefetched entry cannot be marked valid before any slot was written
    a_rd_valid_after_write: assert property (@(posedge clk) disable iff (!rst_n)
        !(|slot_valid_reg) |-> !rd_valid_reg)
        else $error("ring read marked valid before any write");

    // A flagged sample advances the write slot by exactly one
    a_idx_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (s_accept && in_sample_valid) |=>
            (idx_reg == WINDOW_LOG2'($past(idx_reg) + 1'b1)))
        else $error("write slot did not advance on a sample");

    // Without a flagged sample the running state holds
    a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_accept && in_sample_valid) |=> ($stable(sum_reg) && $stable(idx_reg)))
        else $error("running sum or slot changed without a sample");

    // An accepted tick always lands in the middle stage
    a_s1_fill: assert property (@(posedge clk) disable iff (!rst_n)
        s_accept |=> s1_valid_reg)
        else $error("accepted tick lost before the middle stage");

endmodule
